FILE: design/debug_packet_receiver_unit_macros.svh
// assertion macros for the debug packet receiver
// used by the top level; expects clk and arst_n in scope
`ifndef DEBUG_PACKET_RECEIVER_UNIT_MACROS_SVH
`define DEBUG_PACKET_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DPR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpr check failed");

// next-cycle implication, disabled while in reset
`define DPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpr check failed");

`endif

FILE: design/dpr_pkg.sv
// shared types, codes and hex helpers for the debug packet receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpr_pkg;

	// framing characters
	localparam logic [7:0] CH_START = 8'h24;
	localparam logic [7:0] CH_END   = 8'h23;
	localparam logic [7:0] CH_ESC   = 8'h7D;
	localparam logic [7:0] CH_ACK   = 8'h2B;
	localparam logic [7:0] CH_NAK   = 8'h2D;
	localparam logic [7:0] ESC_FLIP = 8'h20;

	// result kinds
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// error causes
	localparam logic [1:0] CAUSE_NONE     = 2'd0;
	localparam logic [1:0] CAUSE_CHECK    = 2'd1;
	localparam logic [1:0] CAUSE_OVERFLOW = 2'd2;

	localparam int         LEN_W         = 12;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd1023;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_PAYLOAD = 3'd1,
		PH_ESCAPE  = 3'd2,
		PH_DIGIT1  = 3'd3,
		PH_DIGIT2  = 3'd4
	} phase_t;

	// one result item plus its emit flag
	typedef struct packed {
		logic       emit;
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] error_cause;
	} result_t;

	// lower-case hex digit test
	function automatic logic hex_ok(input logic [7:0] c);
		hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
	endfunction

	// digit value, zero for a bad digit
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_val = c[3:0];
		end else if (c >= 8'h61 && c <= 8'h66) begin
			hex_val = c[3:0] + 4'd9;
		end else begin
			hex_val = 4'd0;
		end
	endfunction

endpackage

`default_nettype wire

FILE: design/dpr_ifs.sv
// channel interfaces: received bytes, result items, config writes
// depends on dpr_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface dpr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dpr_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data;
	logic [1:0] error_cause;
	modport source (output valid, output kind, output data, output error_cause, input ready);
	modport sink   (input valid, input kind, input data, input error_cause, output ready);
endinterface

interface dpr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [dpr_pkg::LEN_W-1:0]   max_payload_len;
	modport source (output valid, output max_payload_len, input ready);
	modport sink   (input valid, input max_payload_len, output ready);
endinterface

`default_nettype wire

FILE: design/dpr_in_stage.sv
// input register stage for received bytes
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module dpr_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	output logic            in_ready,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// stage is free when empty or draining this cycle
	assign in_ready = !valid_s1 || advance;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

`default_nettype wire

FILE: design/dpr_decode.sv
// packet decoder: framing state, checksum, length check and result choice
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_decode (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid_s1,
	input  wire logic [7:0]                byte_s1,
	input  wire logic [dpr_pkg::LEN_W-1:0] max_len,
	input  wire logic                      out_free,
	output logic                           advance,
	output dpr_pkg::result_t               res,
	output dpr_pkg::phase_t                phase
);

	dpr_pkg::phase_t           phase_q, phase_d;
	logic [7:0]                sum_q, sum_d;
	logic [dpr_pkg::LEN_W-1:0] count_q, count_d;
	logic [3:0]                hi_q, hi_d;
	logic                      bad_q, bad_d;

	logic       is_end, is_esc, is_start, overflow, digit_ok, check_ok;
	logic [7:0] sum_add;

	assign advance  = valid_s1 && out_free;
	assign phase    = phase_q;

	// shared byte decode
	assign is_end   = (byte_s1 == dpr_pkg::CH_END);
	assign is_esc   = (byte_s1 == dpr_pkg::CH_ESC);
	assign is_start = (byte_s1 == dpr_pkg::CH_START);
	assign overflow = (count_q >= max_len);
	assign digit_ok = dpr_pkg::hex_ok(byte_s1);
	assign sum_add  = sum_q + byte_s1;
	assign check_ok = digit_ok && !bad_q && ({hi_q, dpr_pkg::hex_val(byte_s1)} == sum_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			dpr_pkg::PH_PAYLOAD: begin
				if (is_end) begin
					phase_d = dpr_pkg::PH_DIGIT1;
				end else if (overflow) begin
					phase_d = dpr_pkg::PH_HUNT;
				end else if (is_esc) begin
					phase_d = dpr_pkg::PH_ESCAPE;
				end
			end
			dpr_pkg::PH_ESCAPE: phase_d = dpr_pkg::PH_PAYLOAD;
			dpr_pkg::PH_DIGIT1: phase_d = dpr_pkg::PH_DIGIT2;
			dpr_pkg::PH_DIGIT2: phase_d = dpr_pkg::PH_HUNT;
			default: begin
				phase_d = is_start ? dpr_pkg::PH_PAYLOAD : dpr_pkg::PH_HUNT;
			end
		endcase
	end

	// packet datapath and result
	always_comb begin
		sum_d           = sum_q;
		count_d         = count_q;
		hi_d            = hi_q;
		bad_d           = bad_q;
		res.emit        = 1'b0;
		res.kind        = dpr_pkg::KIND_DATA;
		res.data        = byte_s1;
		res.error_cause = dpr_pkg::CAUSE_NONE;
		unique case (phase_q)
			dpr_pkg::PH_PAYLOAD: begin
				if (!is_end) begin
					if (overflow) begin
						sum_d           = 8'd0;
						count_d         = '0;
						hi_d            = 4'd0;
						bad_d           = 1'b0;
						res.emit        = 1'b1;
						res.kind        = dpr_pkg::KIND_REJECT;
						res.data        = dpr_pkg::CH_NAK;
						res.error_cause = dpr_pkg::CAUSE_OVERFLOW;
					end else begin
						sum_d = sum_add;
						if (!is_esc) begin
							count_d  = count_q + 1'b1;
							res.emit = 1'b1;
						end
					end
				end
			end
			dpr_pkg::PH_ESCAPE: begin
				sum_d    = sum_add;
				count_d  = count_q + 1'b1;
				res.emit = 1'b1;
				res.data = byte_s1 ^ dpr_pkg::ESC_FLIP;
			end
			dpr_pkg::PH_DIGIT1: begin
				bad_d = bad_q | !digit_ok;
				hi_d  = dpr_pkg::hex_val(byte_s1);
			end
			dpr_pkg::PH_DIGIT2: begin
				sum_d    = 8'd0;
				count_d  = '0;
				hi_d     = 4'd0;
				bad_d    = 1'b0;
				res.emit = 1'b1;
				if (check_ok) begin
					res.kind = dpr_pkg::KIND_ACCEPT;
					res.data = dpr_pkg::CH_ACK;
				end else begin
					res.kind        = dpr_pkg::KIND_REJECT;
					res.data        = dpr_pkg::CH_NAK;
					res.error_cause = dpr_pkg::CAUSE_CHECK;
				end
			end
			default: begin
				if (is_start) begin
					sum_d   = 8'd0;
					count_d = '0;
					hi_d    = 4'd0;
					bad_d   = 1'b0;
				end
			end
		endcase
	end

	// state registers, updated when an item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dpr_pkg::PH_HUNT;
			sum_q   <= 8'd0;
			count_q <= '0;
			hi_q    <= 4'd0;
			bad_q   <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			hi_q    <= hi_d;
			bad_q   <= bad_d;
		end
	end

endmodule

`default_nettype wire

FILE: design/dpr_out_reg.sv
// result register toward the reply/payload consumer
// depends on dpr_pkg
`timescale 1ns / 1ps
`default_nettype none

module dpr_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire dpr_pkg::result_t res,
	output logic                  out_free,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [1:0]            kind,
	output logic [7:0]            data,
	output logic [1:0]            error_cause
);

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind        <= res.kind;
			data        <= res.data;
			error_cause <= res.error_cause;
		end
	end

endmodule

`default_nettype wire

FILE: design/debug_packet_receiver_unit.sv
// top level of the debug packet receiver: input stage, decoder, result register
// depends on dpr_pkg, dpr_ifs, dpr_in_stage, dpr_decode, dpr_out_reg and the macro header
//
// channel   direction  carries
// rx_in     in         rx_byte, one received serial byte per item
// res_out   out        kind, data, error_cause, one result item
// cfg       in         max_payload_len write
//
// one item per cycle sustained while the result register is not stalled; each byte is registered in the input
// register, then decoded, and a result it yields is registered in the result register.
// a byte that yields no result still passes through the decoder.
// reset clears the framing state to hunting and max_payload_len to 1023.
// a stalled result register holds the input stage only once a new item is waiting there.
`timescale 1ns / 1ps
`default_nettype none
`include "debug_packet_receiver_unit_macros.svh"

module debug_packet_receiver_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	dpr_byte_if.sink      rx_in,
	dpr_result_if.source  res_out,
	dpr_cfg_if.sink       cfg
);

	logic [dpr_pkg::LEN_W-1:0] max_len_q;
	logic                      valid_s1;
	logic [7:0]                byte_s1;
	logic                      advance;
	logic                      out_free;
	logic                      load;
	dpr_pkg::result_t          res;
	dpr_pkg::phase_t           phase;

	// config register, always ready
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= dpr_pkg::MAX_LEN_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_payload_len;
		end
	end

	dpr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rx_in.valid),
		.in_byte  (rx_in.rx_byte),
		.in_ready (rx_in.ready),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	dpr_decode u_dec (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.max_len  (max_len_q),
		.out_free (out_free),
		.advance  (advance),
		.res      (res),
		.phase    (phase)
	);

	assign load = advance && res.emit;

	dpr_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.res         (res),
		.out_free    (out_free),
		.out_valid   (res_out.valid),
		.out_ready   (res_out.ready),
		.kind        (res_out.kind),
		.data        (res_out.data),
		.error_cause (res_out.error_cause)
	);

	// accept carries the ack character and no cause
	`DPR_ASSERT_NOW(a_accept_fields, res_out.valid && res_out.kind == dpr_pkg::KIND_ACCEPT, res_out.data == dpr_pkg::CH_ACK && res_out.error_cause == dpr_pkg::CAUSE_NONE)
	// reject carries the nak character and a cause
	`DPR_ASSERT_NOW(a_reject_fields, res_out.valid && res_out.kind == dpr_pkg::KIND_REJECT, res_out.data == dpr_pkg::CH_NAK && res_out.error_cause != dpr_pkg::CAUSE_NONE)
	// a verdict always returns the framer to hunting
	`DPR_ASSERT_NEXT(a_verdict_hunt, load && res.kind != dpr_pkg::KIND_DATA, phase == dpr_pkg::PH_HUNT)

endmodule

`default_nettype wire

FILE: sim/debug_packet_receiver_unit_test.sv
// self-checking bench for the debug packet receiver: framing, escapes, checksum, overflow
// depends on dpr_pkg, dpr_ifs and the debug_packet_receiver_unit top level
// a scoreboard class decodes every accepted byte and checks each reply item in order
`timescale 1ns / 1ps

module debug_packet_receiver_unit_test;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_CYCLES  = 8;
	localparam int RANDOM_ITEMS = 1900;
	localparam int NUM_PHASES   = 9;

	// ways a generated packet can be damaged
	typedef enum int {
		FLAW_NONE,
		FLAW_SUM,
		FLAW_DIGIT1,
		FLAW_DIGIT2,
		FLAW_UPPER,
		FLAW_CUT
	} flaw_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [1:0] cause;
	} reply_t;

	// decoder mirror plus the queue of replies it still owes
	class packet_tracker;
		dpr_pkg::phase_t ph;
		logic [7:0]  sum;
		logic [11:0] count;
		logic [3:0]  high_nib;
		bit          digit_bad;
		logic [11:0] max_len;
		reply_t      replies_due[$];
		int          taken;
		int          mismatches;
		int          n_data;
		int          n_accept;
		int          n_bad_sum;
		int          n_overflow;

		function new();
			max_len = dpr_pkg::MAX_LEN_RESET;
			clear_packet();
		endfunction

		function void clear_packet();
			ph = dpr_pkg::PH_HUNT;
			sum = 8'd0;
			count = 12'd0;
			high_nib = 4'd0;
			digit_bad = 1'b0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return (c >= "0" && c <= "9") || (c >= "a" && c <= "f");
		endfunction

		function logic [3:0] nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return 4'(c - "0");
			end
			if (c >= "a" && c <= "f") begin
				return 4'(c - "a" + 10);
			end
			return 4'd0;
		endfunction

		function void owe(logic [1:0] kind, logic [7:0] data, logic [1:0] cause);
			reply_t r;
			r.kind = kind;
			r.data = data;
			r.cause = cause;
			replies_due.push_back(r);
		endfunction

		function void set_max_len(logic [11:0] v);
			max_len = v;
		endfunction

		function int pending();
			return replies_due.size();
		endfunction

		// one accepted byte from the link
		function void take_byte(logic [7:0] c);
			bit ok;
			taken++;
			case (ph)
				dpr_pkg::PH_PAYLOAD: begin
					if (c == dpr_pkg::CH_END) begin
						ph = dpr_pkg::PH_DIGIT1;
					end else if (count >= max_len) begin
						clear_packet();
						owe(dpr_pkg::KIND_REJECT, dpr_pkg::CH_NAK, dpr_pkg::CAUSE_OVERFLOW);
					end else begin
						sum = sum + c;
						if (c == dpr_pkg::CH_ESC) begin
							ph = dpr_pkg::PH_ESCAPE;
						end else begin
							count = count + 12'd1;
							owe(dpr_pkg::KIND_DATA, c, dpr_pkg::CAUSE_NONE);
						end
					end
				end
				dpr_pkg::PH_ESCAPE: begin
					sum = sum + c;
					count = count + 12'd1;
					ph = dpr_pkg::PH_PAYLOAD;
					owe(dpr_pkg::KIND_DATA, c ^ dpr_pkg::ESC_FLIP, dpr_pkg::CAUSE_NONE);
				end
				dpr_pkg::PH_DIGIT1: begin
					if (!is_digit(c)) begin
						digit_bad = 1'b1;
					end
					high_nib = nibble_of(c);
					ph = dpr_pkg::PH_DIGIT2;
				end
				dpr_pkg::PH_DIGIT2: begin
					ok = is_digit(c) && !digit_bad && {high_nib, nibble_of(c)} == sum;
					clear_packet();
					if (ok) begin
						owe(dpr_pkg::KIND_ACCEPT, dpr_pkg::CH_ACK, dpr_pkg::CAUSE_NONE);
					end else begin
						owe(dpr_pkg::KIND_REJECT, dpr_pkg::CH_NAK, dpr_pkg::CAUSE_CHECK);
					end
				end
				default: begin
					if (c == dpr_pkg::CH_START) begin
						clear_packet();
						ph = dpr_pkg::PH_PAYLOAD;
					end
				end
			endcase
		endfunction

		// one reply item seen on the output
		function void check_reply(logic [1:0] kind, logic [7:0] data, logic [1:0] cause);
			reply_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected reply: kind %0d data %02h cause %0d",
						kind, data, cause);
				end
				return;
			end
			want = replies_due.pop_front();
			if (kind !== want.kind || data !== want.data || cause !== want.cause) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("reply mismatch: expected kind %0d data %02h cause %0d,",
						want.kind, want.data, want.cause);
					$display("  got kind %0d data %02h cause %0d", kind, data, cause);
				end
			end
			case (want.kind)
				dpr_pkg::KIND_DATA:   n_data++;
				dpr_pkg::KIND_ACCEPT: n_accept++;
				default: begin
					if (want.cause == dpr_pkg::CAUSE_OVERFLOW) begin
						n_overflow++;
					end else begin
						n_bad_sum++;
					end
				end
			endcase
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   cycle_count = 0;
	bit   no_idle = 1'b0;
	packet_tracker board;

	dpr_byte_if   rx_if();
	dpr_result_if res_if();
	dpr_cfg_if    cfg_if();

	debug_packet_receiver_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_in   (rx_if),
		.res_out (res_if),
		.cfg     (cfg_if)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// send one byte, with a random gap before it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (rx_if.ready !== 1'b1) @(posedge clk);
		board.take_byte(b);
	endtask

	// let every owed reply come back and the pipeline empty
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [11:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.max_payload_len <= v;
		@(posedge clk);
		while (cfg_if.ready !== 1'b1) @(posedge clk);
		board.set_max_len(v);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) begin
			return 8'("0" + n);
		end
		return 8'((upper ? "A" : "a") + n - 10);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (board.is_digit(c)) c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// frame a raw body as '$' body '#' digits, damaged as asked
	task automatic send_raw_packet(input logic [7:0] body[$], input flaw_t flaw);
		logic [7:0] sum;
		logic [7:0] bad_sum;
		logic [7:0] line[$];
		int cut;
		sum = 8'd0;
		foreach (body[i]) sum = sum + body[i];
		bad_sum = sum ^ 8'($urandom_range(1, 255));
		line = {dpr_pkg::CH_START};
		foreach (body[i]) line.push_back(body[i]);
		line.push_back(dpr_pkg::CH_END);
		case (flaw)
			FLAW_SUM:    line = {line, hex_char(bad_sum[7:4], 0), hex_char(bad_sum[3:0], 0)};
			FLAW_DIGIT1: line = {line, non_hex_byte(), hex_char(sum[3:0], 0)};
			FLAW_DIGIT2: line = {line, hex_char(sum[7:4], 0), non_hex_byte()};
			FLAW_UPPER:  line = {line, hex_char(sum[7:4], 1), hex_char(sum[3:0], 1)};
			FLAW_CUT: begin
				cut = $urandom_range(1, line.size());
				while (line.size() > cut) void'(line.pop_back());
			end
			default:     line = {line, hex_char(sum[7:4], 0), hex_char(sum[3:0], 0)};
		endcase
		foreach (line[i]) send_byte(line[i]);
	endtask

	// mostly well-formed packets with random content, some noise and damage
	task automatic send_random_packet();
		logic [7:0] body[$];
		logic [7:0] d;
		int len;
		int pick;
		flaw_t flaw;
		no_idle = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
		end
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			len = 0;
		end else if (pick < 85) begin
			len = $urandom_range(1, 12);
		end else if (pick < 97) begin
			len = $urandom_range(13, 40);
		end else begin
			len = $urandom_range(41, 300);
		end
		body = {};
		repeat (len) begin
			d = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 4))
					0: d = dpr_pkg::CH_START;
					1: d = dpr_pkg::CH_END;
					2: d = dpr_pkg::CH_ESC;
					3: d = 8'h00;
					default: d = 8'hFF;
				endcase
			end
			// end and escape bytes and some others go out escaped
			if (d == dpr_pkg::CH_END || d == dpr_pkg::CH_ESC || $urandom_range(0, 7) == 0) begin
				body.push_back(dpr_pkg::CH_ESC);
				body.push_back(d ^ dpr_pkg::ESC_FLIP);
			end else begin
				body.push_back(d);
			end
		end
		pick = $urandom_range(0, 99);
		if (pick < 72) begin
			flaw = FLAW_NONE;
		end else if (pick < 82) begin
			flaw = FLAW_SUM;
		end else if (pick < 88) begin
			flaw = FLAW_DIGIT1;
		end else if (pick < 93) begin
			flaw = FLAW_DIGIT2;
		end else if (pick < 96) begin
			flaw = FLAW_UPPER;
		end else begin
			flaw = FLAW_CUT;
		end
		send_raw_packet(body, flaw);
	endtask

	// reply side with random stalls
	initial begin : reply_sink
		int stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			@(posedge clk);
			while (res_if.valid !== 1'b1) @(posedge clk);
			board.check_reply(res_if.kind, res_if.data, res_if.error_cause);
		end
	end

	// reset, directed packets, then random phases under several limits
	initial begin : stimulus
		logic [7:0] body[$];
		logic [11:0] limits[NUM_PHASES];
		int start;
		int goal;
		board = new();
		arst_n <= 1'b0;
		rx_if.valid <= 1'b0;
		rx_if.rx_byte <= 8'h00;
		cfg_if.valid <= 1'b0;
		cfg_if.max_payload_len <= 12'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting, then extremes, '$' in payload and an escaped '#'
		no_idle = 1'b1;
		send_byte(8'hFF);
		send_byte(8'h00);
		body = {8'h00, 8'hFF, dpr_pkg::CH_START, dpr_pkg::CH_ESC, dpr_pkg::CH_END};
		send_raw_packet(body, FLAW_NONE);
		no_idle = 1'b0;
		body = {};
		send_raw_packet(body, FLAW_DIGIT2);
		body = {8'h61};
		send_raw_packet(body, FLAW_DIGIT1);
		body = {8'h7E};
		send_raw_packet(body, FLAW_SUM);
		wait_idle();

		// zero limit: empty payload still checked, any byte overflows
		write_max_len(12'd0);
		body = {};
		send_raw_packet(body, FLAW_NONE);
		body = {8'h41};
		send_raw_packet(body, FLAW_NONE);
		wait_idle();

		limits = '{12'd1, 12'd4095, 12'd0, 12'd2, 12'd5, 12'd16, 12'd1023,
			12'($urandom_range(1, 4095)), 12'($urandom_range(1, 30))};
		start = board.taken;
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_max_len(limits[p]);
			goal = start + (p + 1) * RANDOM_ITEMS / NUM_PHASES;
			while (board.taken < goal) send_random_packet();
			no_idle = 1'b0;
			wait_idle();
		end

		$display("run covered %0d bytes over %0d limit settings: %0d payload bytes, %0d accepts",
			board.taken, NUM_PHASES + 2, board.n_data, board.n_accept);
		$display("rejects: %0d by checksum or digit, %0d by overflow; %0d mismatches",
			board.n_bad_sum, board.n_overflow, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
